// File: rtl/sawtc_pkg.sv
// Shared types and codes for the set-associative write-through cache.
// No dependencies; every other file of the cache imports this package.
`timescale 1ns / 1ps
package sawtc_pkg;

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_BEAT   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_REFILL = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [2:0]  length;
    logic [31:0] write_data;
    logic [63:0] fill_data;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_data;
    logic [31:0] mem_address;
    logic [2:0]  mem_length;
    logic [31:0] mem_data;
  } rsp_item_t;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic load;
    logic tag_rd;
    logic tag_fill_sel;
    logic rd_byte;
    logic wr_byte;
    logic capture;
    logic next_byte;
    logic start_refill;
    logic beat;
    logic tag_set;
    logic replay;
    logic emit_read;
    logic emit_write;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    logic       out_busy;
    logic       hit;
    logic       fill_last;
    logic       clr_last;
    logic       last_byte;
    logic       is_write;
  } status_t;

endpackage

// File: rtl/sawtc_req_if.sv
// Request channel of the cache: valid/ready handshake with a request item.
// Depends on sawtc_pkg.
`timescale 1ns / 1ps
interface sawtc_req_if;
  import sawtc_pkg::*;
  logic      valid;
  logic      ready;
  req_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/sawtc_rsp_if.sv
// Response channel of the cache: valid/ready handshake with a result item.
// Depends on sawtc_pkg.
`timescale 1ns / 1ps
interface sawtc_rsp_if;
  import sawtc_pkg::*;
  logic      valid;
  logic      ready;
  rsp_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/set_assoc_write_through_cache_unit.sv
// Set-associative write-through data cache: top level joining controller
// and datapath. Depends on sawtc_pkg, the channel interfaces, sawtc_ctrl, sawtc_dp.
//
// Use: requests come in on req (read, write or refill beat); results leave on
// rsp (read data, line refill request, write-through). One request is worked
// on at a time. Per byte of an access the controller spends a tag read, a
// hit check and, for reads, a data read. A read miss sends a refill request
// and then waits for LINE_BYTES/8 beat transfers; after the last beat the
// tag row of the refilled set is read and updated, and the whole read is
// replayed. Requests other than beats that arrive during a refill are taken
// and dropped, as are beats outside a refill. These per-byte steps follow
// from the sequencer and the single-port line and tag memories.
// After reset the tag memory is cleared one set per cycle while req.ready
// stays low. The result sits in an output register; while the receiver
// stalls it, the block takes no new request.
`timescale 1ns / 1ps
module set_assoc_write_through_cache_unit #(
  parameter int NUM_SETS   = 128,
  parameter int NUM_WAYS   = 8,
  parameter int LINE_BYTES = 64
) (
  input logic         clk,
  input logic         rst,
  sawtc_req_if.sink   req,
  sawtc_rsp_if.source rsp
);
  import sawtc_pkg::*;

  cmd_t    cmd;
  status_t status;

  sawtc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sawtc_dp #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .req    (req),
    .rsp    (rsp)
  );

endmodule

// File: rtl/sawtc_ctrl.sv
// Controller state machine of the cache: sequences tag lookups, byte accesses,
// refills and the reset clearing pass. Depends on sawtc_pkg.
`timescale 1ns / 1ps
module sawtc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  sawtc_pkg::status_t status,
  output sawtc_pkg::cmd_t    cmd
);
  import sawtc_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TAG   = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_BYTE  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;
  localparam logic [2:0] S_FTAG  = 3'd6;
  localparam logic [2:0] S_FSET  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;

  assign take = status.in_valid && !status.out_busy;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.in_ready = !status.out_busy;
        if (take && (status.in_op == OP_READ || status.in_op == OP_WRITE)) begin
          cmd.load   = 1'b1;
          state_next = S_TAG;
        end
      end
      S_TAG: begin
        cmd.tag_rd = 1'b1;
        state_next = S_HIT;
      end
      S_HIT: begin
        if (status.is_write) begin
          cmd.wr_byte = status.hit;
          if (status.last_byte) begin
            cmd.emit_write = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.next_byte = 1'b1;
            state_next    = S_TAG;
          end
        end else if (status.hit) begin
          cmd.rd_byte = 1'b1;
          state_next  = S_BYTE;
        end else begin
          cmd.start_refill = 1'b1;
          state_next       = S_FILL;
        end
      end
      S_BYTE: begin
        cmd.capture = 1'b1;
        if (status.last_byte) begin
          cmd.emit_read = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.next_byte = 1'b1;
          state_next    = S_TAG;
        end
      end
      S_FILL: begin
        cmd.in_ready = !status.out_busy;
        if (take && status.in_op == OP_BEAT) begin
          cmd.beat = 1'b1;
          if (status.fill_last) state_next = S_FTAG;
        end
      end
      S_FTAG: begin
        cmd.tag_rd       = 1'b1;
        cmd.tag_fill_sel = 1'b1;
        state_next       = S_FSET;
      end
      S_FSET: begin
        cmd.tag_set = 1'b1;
        cmd.replay  = 1'b1;
        state_next  = S_TAG;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/sawtc_dp.sv
// Datapath of the cache: tag and line memories, access registers, victim
// LFSR and the result register. Depends on sawtc_pkg and the channel interfaces.
`timescale 1ns / 1ps
module sawtc_dp #(
  parameter int NUM_SETS   = 128,
  parameter int NUM_WAYS   = 8,
  parameter int LINE_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  sawtc_pkg::cmd_t    cmd,
  output sawtc_pkg::status_t status,
  sawtc_req_if.sink          req,
  sawtc_rsp_if.source        rsp
);
  import sawtc_pkg::*;

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int TAG_W   = 32 - OFF_W - SET_W;
  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int BEATS   = LINE_BYTES / 8;
  localparam int BEAT_W  = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int DEPTH   = NUM_SETS * NUM_WAYS * BEATS;
  localparam int DADDR_W = $clog2(DEPTH);

  typedef logic [NUM_WAYS-1:0][TAG_W:0] row_t;

  row_t        tag_mem [NUM_SETS];
  logic [63:0] data_mem [DEPTH];

  row_t              tag_q;
  logic [63:0]       data_q;
  logic [SET_W-1:0]  clr_idx;
  logic              acc_write;
  logic [31:0]       acc_addr;
  logic [2:0]        acc_len;
  logic [31:0]       acc_md;
  logic [1:0]        byte_idx;
  logic [31:0]       rd_acc;
  logic [15:0]       lfsr;
  logic [WAY_W-1:0]  victim;
  logic [31:0]       refill_addr;
  logic [BEAT_W-1:0] beat_cnt;
  logic              out_valid;
  rsp_item_t         out_item;

  logic [2:0]        len_clamp;
  logic [31:0]       md_mask;
  logic [31:0]       cur_addr;
  logic [SET_W-1:0]  cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic [OFF_W-1:0]  cur_off;
  logic [SET_W-1:0]  fill_set;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [DADDR_W-1:0] hit_daddr;
  logic [DADDR_W-1:0] fill_daddr;
  logic [7:0]        wr_byte_val;
  logic [31:0]       rd_acc_next;
  logic [15:0]       lfsr_next;
  logic [WAY_W-1:0]  victim_new;
  row_t              row_inval;
  row_t              row_fill;

  function automatic logic [DADDR_W-1:0] data_addr(input logic [SET_W-1:0] set,
                                                   input logic [WAY_W-1:0] way,
                                                   input logic [BEAT_W-1:0] word);
    data_addr = DADDR_W'(set) * DADDR_W'(NUM_WAYS * BEATS)
              + DADDR_W'(way) * DADDR_W'(BEATS) + DADDR_W'(word);
  endfunction

  always_comb begin
    if (req.payload.length == 3'd0) len_clamp = 3'd1;
    else if (req.payload.length > 3'd4) len_clamp = 3'd4;
    else len_clamp = req.payload.length;
    case (len_clamp)
      3'd1:    md_mask = 32'h0000_00ff;
      3'd2:    md_mask = 32'h0000_ffff;
      3'd3:    md_mask = 32'h00ff_ffff;
      default: md_mask = 32'hffff_ffff;
    endcase
  end

  assign cur_addr = acc_addr + 32'(byte_idx);
  assign cur_set  = cur_addr[OFF_W +: SET_W];
  assign cur_tag  = cur_addr[31 -: TAG_W];
  assign cur_off  = cur_addr[OFF_W-1:0];
  assign fill_set = refill_addr[OFF_W +: SET_W];

  // Lowest-numbered matching valid way wins.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (tag_q[w][TAG_W] && tag_q[w][TAG_W-1:0] == cur_tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  assign hit_daddr   = data_addr(cur_set, hit_way, BEAT_W'(cur_off >> 3));
  assign fill_daddr  = data_addr(fill_set, victim, beat_cnt);
  assign wr_byte_val = acc_md[8*byte_idx +: 8];

  always_comb begin
    rd_acc_next = rd_acc;
    rd_acc_next[8*byte_idx +: 8] = data_q[8*cur_off[2:0] +: 8];
  end

  assign lfsr_next  = (lfsr >> 1) ^ (lfsr[0] ? 16'hB400 : 16'h0000);
  assign victim_new = WAY_W'(lfsr % 16'(NUM_WAYS));

  always_comb begin
    row_inval = tag_q;
    row_inval[victim_new][TAG_W] = 1'b0;
    row_fill = tag_q;
    row_fill[victim] = {1'b1, refill_addr[31 -: TAG_W]};
  end

  // Tag memory: one row of all ways per set.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      tag_mem[clr_idx] <= '0;
    end else if (cmd.start_refill) begin
      tag_mem[cur_set] <= row_inval;
    end else if (cmd.tag_set) begin
      tag_mem[fill_set] <= row_fill;
    end
    if (cmd.tag_rd) begin
      tag_q <= tag_mem[cmd.tag_fill_sel ? fill_set : cur_set];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beat) begin
      data_mem[fill_daddr] <= req.payload.fill_data;
    end else if (cmd.wr_byte) begin
      data_mem[hit_daddr][8*cur_off[2:0] +: 8] <= wr_byte_val;
    end
    if (cmd.rd_byte) begin
      data_q <= data_mem[hit_daddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_write <= (req.payload.operation == OP_WRITE);
      acc_addr  <= req.payload.address;
      acc_len   <= len_clamp;
      acc_md    <= req.payload.write_data & md_mask;
    end
    if (cmd.load || cmd.replay) begin
      byte_idx <= '0;
      rd_acc   <= '0;
    end else begin
      if (cmd.next_byte) byte_idx <= byte_idx + 2'd1;
      if (cmd.capture) rd_acc <= rd_acc_next;
    end
    if (cmd.start_refill) begin
      victim      <= victim_new;
      refill_addr <= {cur_addr[31:OFF_W], OFF_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx  <= '0;
      lfsr     <= 16'h0001;
      beat_cnt <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + SET_W'(1);
      if (cmd.start_refill) begin
        lfsr     <= lfsr_next;
        beat_cnt <= '0;
      end else if (cmd.beat) begin
        beat_cnt <= beat_cnt + BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_read || cmd.emit_write || cmd.start_refill) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_read) begin
      out_item <= '{kind: KIND_READ, read_data: rd_acc_next, mem_address: '0,
                    mem_length: '0, mem_data: '0};
    end else if (cmd.emit_write) begin
      out_item <= '{kind: KIND_WRITE, read_data: '0, mem_address: acc_addr,
                    mem_length: acc_len, mem_data: acc_md};
    end else if (cmd.start_refill) begin
      out_item <= '{kind: KIND_REFILL, read_data: '0,
                    mem_address: {cur_addr[31:OFF_W], OFF_W'(0)},
                    mem_length: '0, mem_data: '0};
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;
  assign req.ready   = cmd.in_ready;

  assign status.in_valid  = req.valid;
  assign status.in_op     = req.payload.operation;
  assign status.out_busy  = out_valid;
  assign status.hit       = hit;
  assign status.fill_last = (beat_cnt == BEAT_W'(BEATS - 1));
  assign status.clr_last  = (clr_idx == SET_W'(NUM_SETS - 1));
  assign status.last_byte = ({1'b0, byte_idx} == acc_len - 3'd1);
  assign status.is_write  = acc_write;

endmodule

// File: rtl/sawtc_checker.sv
// Port-level checks for the cache, attached to the top level by bind.
// Depends on sawtc_pkg and set_assoc_write_through_cache_unit.
`timescale 1ns / 1ps
module sawtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_kind,
  input logic [31:0] rsp_read_data,
  input logic [2:0]  rsp_mem_length,
  input logic [31:0] rsp_mem_data
);
  import sawtc_pkg::*;

  // No result may appear right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_kind == KIND_READ || rsp_kind == KIND_REFILL ||
                   rsp_kind == KIND_WRITE))
    else $error("unknown result kind");

  a_refill_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_REFILL |->
      rsp_mem_length == 3'd0 && rsp_mem_data == 32'd0 && rsp_read_data == 32'd0)
    else $error("refill request carries data");

  a_write_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind == KIND_WRITE |->
      rsp_mem_length != 3'd0 && rsp_mem_length <= 3'd4 && rsp_read_data == 32'd0)
    else $error("bad write-through length");

endmodule

bind set_assoc_write_through_cache_unit sawtc_checker u_sawtc_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_kind       (rsp.payload.kind),
  .rsp_read_data  (rsp.payload.read_data),
  .rsp_mem_length (rsp.payload.mem_length),
  .rsp_mem_data   (rsp.payload.mem_data)
);
